// File: src/atcli_pkg.sv
// shared types, constants and character helpers for the at command line interpreter
`default_nettype none
package atcli_pkg;

    localparam int LINE_CHARS = 32;
    localparam int IDX_W      = $clog2(LINE_CHARS);

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_X     = 8'd88;
    localparam logic [7:0] CH_UA    = 8'd65;
    localparam logic [7:0] CH_UT    = 8'd84;
    localparam logic [7:0] CH_UE    = 8'd69;
    localparam logic [7:0] CH_UO    = 8'd79;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LT    = 8'd116;
    localparam logic [7:0] CH_LE    = 8'd101;
    localparam logic [7:0] CH_LO    = 8'd111;

    // fixed part of the send command after the prefix
    localparam int SEND_FIRST = 2;
    localparam int SEND_LAST  = 8;

    typedef enum logic [1:0] {
        K_EOL,
        K_DEL,
        K_DATA,
        K_ESC
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_t;

    typedef enum logic [2:0] {
        TXT_OK,
        TXT_ERROR,
        TXT_INVALID,
        TXT_ON,
        TXT_OFF,
        TXT_NLOK,
        TXT_SENT,
        TXT_TAIL
    } text_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN,
        S_P0,
        S_P1,
        S_P2,
        S_SEND,
        S_QSCAN,
        S_TEXT,
        S_PAY,
        S_ESP,
        S_ESG,
        S_EDG,
        S_FINISH
    } bstate_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'd48) && (b <= 8'd57);
    endfunction

    function automatic logic [7:0] to_wire(input logic [7:0] b);
        logic [7:0] r;
        if (b >= CH_LA && b <= 8'd122)
            r = b - 8'd32;
        else if ((b >= CH_UA && b <= 8'd90) || is_digit(b))
            r = b;
        else if (is_space(b))
            r = CH_SPACE;
        else
            r = CH_X;
        return r;
    endfunction

    function automatic logic [3:0] text_len(input text_t id);
        logic [3:0] n;
        case (id)
            TXT_OK:      n = 4'd3;
            TXT_ERROR:   n = 4'd6;
            TXT_INVALID: n = 4'd8;
            TXT_ON:      n = 4'd6;
            TXT_OFF:     n = 4'd7;
            TXT_NLOK:    n = 4'd4;
            TXT_SENT:    n = 4'd6;
            TXT_TAIL:    n = 4'd5;
            default:     n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] text_char(input text_t id, input logic [2:0] pos);
        logic [63:0] s;
        logic [2:0]  sh;
        case (id)
            TXT_OK:      s = 64'("OK\n");
            TXT_ERROR:   s = 64'("ERROR\n");
            TXT_INVALID: s = 64'("INVALID\n");
            TXT_ON:      s = 64'("ON\nOK\n");
            TXT_OFF:     s = 64'("OFF\nOK\n");
            TXT_NLOK:    s = 64'("\nOK\n");
            TXT_SENT:    s = 64'("SENT=\"");
            TXT_TAIL:    s = 64'("\"\nOK\n");
            default:     s = 64'd0;
        endcase
        sh = 3'(text_len(id) - 4'd1 - {1'b0, pos});
        return 8'(s >> {sh, 3'b000});
    endfunction

    function automatic logic [7:0] send_pfx(input logic [2:0] k);
        logic [55:0] s;
        s = 56'("+SEND=\"");
        return 8'(s >> {3'(3'd6 - k), 3'b000});
    endfunction

endpackage
`default_nettype wire

// File: src/atcli_front.sv
// input side: takes bytes and idle ticks, classifies them and queues commands
`default_nettype none
module atcli_front
    import atcli_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       operation,
    input  wire logic [7:0] char_code,
    input  wire logic       escape_seen,
    output logic            cmd_valid,
    output cmd_t            cmd,
    input  wire logic       cmd_pop
);

    cmd_t       ent_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       wr;
    logic       rd;
    cmd_t       cls;

    always_comb
    begin
        cls.data = char_code;
        if (operation)
            cls.kind = K_ESC;
        else if (char_code == CH_CR || char_code == CH_LF)
            cls.kind = K_EOL;
        else if (char_code == CH_DEL)
            cls.kind = K_DEL;
        else
            cls.kind = K_DATA;
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = ent_reg[rptr_reg];
    // an idle tick without escape never does anything, so it is dropped here
    assign wr        = push && !full && (!operation || escape_seen);
    assign rd        = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (wr)
            ent_reg[wptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
                wptr_reg <= !wptr_reg;
            if (rd)
                rptr_reg <= !rptr_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, wr} - {1'b0, rd});
        end
    end

endmodule
`default_nettype wire

// File: src/atcli_outq.sv
// result queue of response bytes
`default_nettype none
module atcli_outq
    import atcli_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr,
    input  out_t            wdata,
    output logic            oq_full,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_char,
    output logic            last_of_run
);

    out_t       ent_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       rd;
    logic       wen;

    assign oq_full     = (cnt_reg == 2'd2);
    assign empty       = (cnt_reg == 2'd0);
    assign out_char    = ent_reg[rptr_reg].ch;
    assign last_of_run = ent_reg[rptr_reg].last;
    assign rd          = pop && !empty;
    assign wen         = wr && !oq_full;

    always_ff @(posedge clk)
    begin
        if (wen)
            ent_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wen)
                wptr_reg <= !wptr_reg;
            if (rd)
                rptr_reg <= !rptr_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, wen} - {1'b0, rd});
        end
    end

endmodule
`default_nettype wire

// File: src/atcli_back.sv
// command side: line buffer, command parser and response sequencer
`default_nettype none
module atcli_back
    import atcli_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  cmd_t            cmd,
    output logic            cmd_pop,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_data,
    output logic            oq_wr,
    output out_t            oq_wdata,
    input  wire logic       oq_full
);

    logic [7:0]       mem [LINE_CHARS];
    logic [7:0]       cur_reg;
    logic             mem_wr;
    logic [IDX_W-1:0] raddr;

    bstate_t          state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] q_reg, q_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             online_reg, online_next;
    logic             echo_reg, echo_next;
    logic             any_reg, any_next;
    logic             nz_reg, nz_next;
    text_t            txt_reg, txt_next;
    logic [2:0]       tpos_reg, tpos_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [7:0]       pend_ch_reg, pend_ch_next;
    logic [7:0]       c0_reg, c0_next;

    logic             can_emit;
    logic             emit;
    logic [7:0]       emit_byte;
    logic             flush;

    // cur_reg always holds the line cell at idx_reg
    assign raddr = idx_next;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[fill_reg] <= cmd.data;
        cur_reg <= mem[raddr];
    end

    // a byte is held back one step so the final byte of a run can be marked
    assign can_emit = !pend_vld_reg || !oq_full;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        q_next        = q_reg;
        fill_next     = fill_reg;
        online_next   = online_reg;
        echo_next     = echo_reg;
        any_next      = any_reg;
        nz_next       = nz_reg;
        txt_next      = txt_reg;
        tpos_next     = tpos_reg;
        c0_next       = c0_reg;
        cmd_pop       = 1'b0;
        mem_wr        = 1'b0;
        emit          = 1'b0;
        emit_byte     = cmd.data;
        flush         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == K_ESC)
                    begin
                        cmd_pop = 1'b1;
                        if (online_reg)
                        begin
                            online_next = 1'b0;
                            txt_next    = TXT_NLOK;
                            tpos_next   = 3'd0;
                            state_next  = S_TEXT;
                        end
                    end
                    else if (online_reg)
                    begin
                        if (can_emit)
                        begin
                            cmd_pop    = 1'b1;
                            emit       = 1'b1;
                            emit_byte  = to_wire(cmd.data);
                            state_next = S_FINISH;
                        end
                    end
                    else if (can_emit || !echo_reg)
                    begin
                        cmd_pop    = 1'b1;
                        emit       = echo_reg;
                        state_next = S_FINISH;
                        case (cmd.kind)
                            K_DATA:
                            begin
                                mem_wr = 1'b1;
                                if (fill_reg < IDX_W'(LINE_CHARS - 1))
                                    fill_next = fill_reg + 1'b1;
                            end
                            K_DEL:
                            begin
                                if (fill_reg != '0)
                                    fill_next = fill_reg - 1'b1;
                            end
                            K_EOL:
                            begin
                                idx_next   = '0;
                                state_next = S_LEN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            S_LEN:
            begin
                if (idx_reg < fill_reg && cur_reg != 8'd0)
                    idx_next = idx_reg + 1'b1;
                else
                begin
                    len_next  = idx_reg;
                    fill_next = '0;
                    idx_next  = '0;
                    if (idx_reg == '0)
                        state_next = S_FINISH;
                    else
                        state_next = S_P0;
                end
            end

            S_P0:
            begin
                c0_next    = cur_reg;
                idx_next   = IDX_W'(1);
                state_next = S_P1;
            end

            S_P1:
            begin
                tpos_next = 3'd0;
                if (len_reg < IDX_W'(2)
                    || !((c0_reg == CH_UA && cur_reg == CH_UT)
                         || (c0_reg == CH_LA && cur_reg == CH_LT)))
                begin
                    txt_next   = TXT_ERROR;
                    state_next = S_TEXT;
                end
                else if (len_reg == IDX_W'(2))
                begin
                    txt_next   = TXT_OK;
                    state_next = S_TEXT;
                end
                else
                begin
                    idx_next   = IDX_W'(2);
                    state_next = S_P2;
                end
            end

            S_P2:
            begin
                tpos_next = 3'd0;
                if (cur_reg == CH_UE || cur_reg == CH_LE)
                begin
                    idx_next   = IDX_W'(3);
                    any_next   = 1'b0;
                    nz_next    = 1'b0;
                    state_next = S_ESP;
                end
                else if (cur_reg == CH_UO || cur_reg == CH_LO)
                begin
                    if (len_reg == IDX_W'(3))
                    begin
                        online_next = 1'b1;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        txt_next   = TXT_INVALID;
                        state_next = S_TEXT;
                    end
                end
                else if (len_reg >= IDX_W'(SEND_LAST + 1) && cur_reg == send_pfx(3'd0))
                begin
                    idx_next   = IDX_W'(SEND_FIRST + 1);
                    state_next = S_SEND;
                end
                else
                begin
                    txt_next   = TXT_INVALID;
                    state_next = S_TEXT;
                end
            end

            S_SEND:
            begin
                tpos_next = 3'd0;
                if (cur_reg != send_pfx(3'(idx_reg - IDX_W'(SEND_FIRST))))
                begin
                    txt_next   = TXT_INVALID;
                    state_next = S_TEXT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(SEND_LAST))
                        state_next = S_QSCAN;
                end
            end

            S_QSCAN:
            begin
                tpos_next = 3'd0;
                if (idx_reg < len_reg)
                begin
                    if (cur_reg == CH_QUOTE)
                    begin
                        q_next     = idx_reg;
                        txt_next   = TXT_SENT;
                        state_next = S_TEXT;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    txt_next   = TXT_INVALID;
                    state_next = S_TEXT;
                end
            end

            S_TEXT:
            begin
                emit      = 1'b1;
                emit_byte = text_char(txt_reg, tpos_reg);
                if (can_emit)
                begin
                    tpos_next = tpos_reg + 3'd1;
                    if ({1'b0, tpos_reg} == text_len(txt_reg) - 4'd1)
                    begin
                        if (txt_reg == TXT_SENT)
                        begin
                            idx_next   = IDX_W'(SEND_LAST + 1);
                            state_next = S_PAY;
                        end
                        else
                            state_next = S_FINISH;
                    end
                end
            end

            S_PAY:
            begin
                if (idx_reg < q_reg)
                begin
                    emit      = 1'b1;
                    emit_byte = to_wire(cur_reg);
                    if (can_emit)
                        idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    txt_next   = TXT_TAIL;
                    tpos_next  = 3'd0;
                    state_next = S_TEXT;
                end
            end

            S_ESP:
            begin
                if (idx_reg < len_reg && is_space(cur_reg))
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = S_ESG;
            end

            S_ESG:
            begin
                if (idx_reg < len_reg && (cur_reg == CH_PLUS || cur_reg == CH_MINUS))
                    idx_next = idx_reg + 1'b1;
                state_next = S_EDG;
            end

            S_EDG:
            begin
                tpos_next = 3'd0;
                if (idx_reg < len_reg && is_digit(cur_reg))
                begin
                    any_next = 1'b1;
                    nz_next  = nz_reg || (cur_reg != CH_ZERO);
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_TEXT;
                    if (any_reg)
                    begin
                        echo_next = nz_reg;
                        txt_next  = TXT_OK;
                    end
                    else if (len_reg == IDX_W'(3))
                        txt_next = echo_reg ? TXT_ON : TXT_OFF;
                    else
                        txt_next = TXT_INVALID;
                end
            end

            S_FINISH:
            begin
                if (!pend_vld_reg)
                    state_next = S_IDLE;
                else if (!oq_full)
                begin
                    flush      = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
            echo_next = cfg_data;
    end

    always_comb
    begin
        pend_vld_next  = pend_vld_reg;
        pend_ch_next   = pend_ch_reg;
        oq_wr          = 1'b0;
        oq_wdata.ch    = pend_ch_reg;
        oq_wdata.last  = flush;
        if (flush)
        begin
            oq_wr         = 1'b1;
            pend_vld_next = 1'b0;
        end
        else if (emit && can_emit)
        begin
            oq_wr         = pend_vld_reg;
            pend_vld_next = 1'b1;
            pend_ch_next  = emit_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        q_reg       <= q_next;
        any_reg     <= any_next;
        nz_reg      <= nz_next;
        txt_reg     <= txt_next;
        tpos_reg    <= tpos_next;
        pend_ch_reg <= pend_ch_next;
        c0_reg      <= c0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            fill_reg     <= '0;
            online_reg   <= 1'b0;
            echo_reg     <= 1'b1;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            fill_reg     <= fill_next;
            online_reg   <= online_next;
            echo_reg     <= echo_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

endmodule
`default_nettype wire

// File: src/at_command_line_interpreter.sv
// top level of the at command line interpreter
// a plain byte gives its echo or converted byte through the front queue, the held-back byte and the result queue
// a line end scans the line once for its length and once to parse and reply,
// writing one response byte per cycle while the result queue is not full
// the back sequencer takes one request at a time; the front queue holds two more
// reset: asynchronous, clears the line, command mode, echo on; no clearing pass
`default_nettype none
module at_command_line_interpreter
    import atcli_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       operation,
    input  wire logic [7:0] char_code,
    input  wire logic       escape_seen,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_char,
    output logic            last_of_run,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic oq_wr;
    out_t oq_wdata;
    logic oq_full;

    assign cfg_ready = 1'b1;

    atcli_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .char_code   (char_code),
        .escape_seen (escape_seen),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    atcli_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .oq_wr     (oq_wr),
        .oq_wdata  (oq_wdata),
        .oq_full   (oq_full)
    );

    atcli_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (oq_wr),
        .wdata       (oq_wdata),
        .oq_full     (oq_full),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule
`default_nettype wire
